### design/plb_pkg.sv
// Shared types and constants of the price-level book matcher.
`default_nettype none
package plb_pkg;

  // Book depth in ticks; supported range 2..256 (price is an 8-bit tick index).
  localparam int LEVELS_DEF = 256;

  localparam int PRICE_W = 8;
  localparam int QTY_W   = 16;
  localparam int LQ_W    = 32;
  localparam int FC_W    = 9;
  localparam int FT_W    = 16;
  localparam int TT_W    = 48;

  // Bits per group of the two-stage best-level search.
  localparam int GRP = 16;

  localparam logic [FC_W-1:0] FC_MAX = '1;
  localparam logic [FT_W-1:0] FT_MAX = '1;
  localparam logic [LQ_W-1:0] LQ_MAX = '1;

  typedef enum logic [1:0] {
    K_ADD  = 2'd0,
    K_ZERO = 2'd1,
    K_OOB  = 2'd2
  } kind_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    kind_t              kind;
    logic               is_ask;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } req_t;

endpackage
`default_nettype wire

### design/plb_if.sv
// Channel interfaces for requests in and results out.
`default_nettype none
interface plb_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [plb_pkg::PRICE_W-1:0] price_level;
  logic [plb_pkg::QTY_W-1:0]   quantity;

  modport source (output valid, action, price_level, quantity, input ready);
  modport sink   (input valid, action, price_level, quantity, output ready);
endinterface

interface plb_out_if;
  logic                        valid;
  logic                        ready;
  logic [plb_pkg::FC_W-1:0]    fill_count;
  logic [plb_pkg::FT_W-1:0]    filled_total;
  logic [plb_pkg::PRICE_W-1:0] best_bid_level;
  logic                        bid_present;
  logic [plb_pkg::PRICE_W-1:0] best_ask_level;
  logic                        ask_present;
  logic [plb_pkg::TT_W-1:0]    trade_total;
  logic                        zero_rejected;

  modport source (output valid, fill_count, filled_total, best_bid_level, bid_present,
                  best_ask_level, ask_present, trade_total, zero_rejected, input ready);
  modport sink   (input valid, fill_count, filled_total, best_bid_level, bid_present,
                  best_ask_level, ask_present, trade_total, zero_rejected, output ready);
endinterface
`default_nettype wire

### design/plb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module plb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

### design/plb_front.sv
// Front end: accept requests, classify them and hold them in a two-entry queue.
`default_nettype none
module plb_front #(
  parameter int LEVELS = plb_pkg::LEVELS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  plb_in_if.sink        in_chan,
  output logic          q_valid,
  output plb_pkg::req_t q_item,
  input  wire logic     q_pop
);

  plb_pkg::req_t slot_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  plb_pkg::req_t cls;
  logic          push;
  logic          pop;

  always_comb begin
    cls.is_ask = in_chan.action;
    cls.price  = in_chan.price_level;
    cls.qty    = in_chan.quantity;
    if (in_chan.quantity == '0) begin
      cls.kind = plb_pkg::K_ZERO;
    end else if (int'(in_chan.price_level) >= LEVELS) begin
      cls.kind = plb_pkg::K_OOB;
    end else begin
      cls.kind = plb_pkg::K_ADD;
    end
  end

  assign in_chan.ready = (cnt_r != 2'd2);
  assign push    = in_chan.valid && in_chan.ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = slot_r[rd_ptr_r];
  assign pop     = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cls;
    end
  end

endmodule
`default_nettype wire

### design/plb_find.sv
// Two-stage registered search for the highest or lowest set bit of a level map.
`default_nettype none
module plb_find #(
  parameter int LEVELS  = plb_pkg::LEVELS_DEF,
  parameter bit HIGHEST = 1'b1
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [LEVELS-1:0]         map,
  output logic [$clog2(LEVELS)-1:0]      idx,
  output logic                           found
);

  localparam int G   = plb_pkg::GRP;
  localparam int NG  = (LEVELS + G - 1) / G;
  localparam int GW  = (NG > 1) ? $clog2(NG) : 1;
  localparam int IW  = $clog2(LEVELS);

  logic [NG*G-1:0] pad;
  logic [NG-1:0]   grp_any;
  logic [GW-1:0]   grp_pick;
  logic [GW-1:0]   grp_r;
  logic            grp_hit_r;
  logic [G-1:0]    sub;
  logic [3:0]      sub_pick;
  logic [IW-1:0]   idx_r;
  logic            found_r;

  assign pad = (NG*G)'(map);

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_any[g] = |pad[g*G +: G];
    end
  end

  // Pick the group: last hit wins, scan order sets highest or lowest.
  always_comb begin
    grp_pick = '0;
    if (HIGHEST) begin
      for (int g = 0; g < NG; g++) begin
        if (grp_any[g]) grp_pick = GW'(g);
      end
    end else begin
      for (int g = NG - 1; g >= 0; g--) begin
        if (grp_any[g]) grp_pick = GW'(g);
      end
    end
  end

  assign sub = pad[grp_r*G +: G];

  always_comb begin
    sub_pick = '0;
    if (HIGHEST) begin
      for (int b = 0; b < G; b++) begin
        if (sub[b]) sub_pick = 4'(b);
      end
    end else begin
      for (int b = G - 1; b >= 0; b--) begin
        if (sub[b]) sub_pick = 4'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_r     <= '0;
      grp_hit_r <= 1'b0;
      idx_r     <= '0;
      found_r   <= 1'b0;
    end else begin
      grp_r     <= grp_pick;
      grp_hit_r <= |grp_any;
      idx_r     <= IW'({grp_r, sub_pick});
      found_r   <= grp_hit_r && (|sub);
    end
  end

  assign idx   = found_r ? idx_r : '0;
  assign found = found_r;

endmodule
`default_nettype wire

### design/plb_back.sv
// Back end: apply the add, run the match loop and present the result.
`default_nettype none
module plb_back #(
  parameter int LEVELS = plb_pkg::LEVELS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire plb_pkg::req_t q_item,
  output logic               q_pop,
  plb_out_if.source          out_chan
);

  localparam int IW = $clog2(LEVELS);
  localparam int LQ = plb_pkg::LQ_W;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_RD   = 7'b0000010,
    ST_S1   = 7'b0000100,
    ST_S2   = 7'b0001000,
    ST_CHK  = 7'b0010000,
    ST_MRD  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } st_t;

  st_t                        st_r, st_nxt;
  plb_pkg::req_t              cur_r, cur_nxt;
  logic [plb_pkg::FC_W-1:0]   fc_r, fc_nxt;
  logic [plb_pkg::FT_W-1:0]   ft_r, ft_nxt;
  logic [plb_pkg::TT_W-1:0]   tt_r, tt_nxt;
  logic [LEVELS-1:0]          nb_r, nb_nxt;
  logic [LEVELS-1:0]          na_r, na_nxt;
  logic                       ov_r, ov_nxt;
  logic [plb_pkg::FC_W-1:0]   o_fc_r, o_fc_nxt;
  logic [plb_pkg::FT_W-1:0]   o_ft_r, o_ft_nxt;
  logic [plb_pkg::PRICE_W-1:0] o_bb_r, o_bb_nxt, o_ba_r, o_ba_nxt;
  logic                       o_hb_r, o_hb_nxt, o_ha_r, o_ha_nxt;
  logic [plb_pkg::TT_W-1:0]   o_tt_r, o_tt_nxt;
  logic                       o_zr_r, o_zr_nxt;

  logic [IW-1:0] bb, ba;
  logic          hb, ha;
  logic [IW-1:0] cur_idx, head_idx;
  logic          bid_we, ask_we;
  logic [IW-1:0] bid_waddr, ask_waddr, bid_raddr, ask_raddr;
  logic [LQ-1:0] bid_wdata, ask_wdata, bid_rdata, ask_rdata;
  logic [LQ-1:0] old_q, add_q, fill_q, bid_left, ask_left;
  logic [LQ:0]   add_sum;
  logic [plb_pkg::FT_W:0] ft_sum;
  logic          crossed;
  logic          out_load;

  assign cur_idx  = IW'(cur_r.price);
  assign head_idx = IW'(q_item.price);

  plb_find #(.LEVELS(LEVELS), .HIGHEST(1'b1)) u_find_bid (
    .clk(clk), .rst_n(rst_n), .map(nb_r), .idx(bb), .found(hb)
  );
  plb_find #(.LEVELS(LEVELS), .HIGHEST(1'b0)) u_find_ask (
    .clk(clk), .rst_n(rst_n), .map(na_r), .idx(ba), .found(ha)
  );

  plb_ram #(.WIDTH(LQ), .DEPTH(LEVELS)) u_bid_ram (
    .clk(clk), .we(bid_we), .waddr(bid_waddr), .wdata(bid_wdata),
    .raddr(bid_raddr), .rdata(bid_rdata)
  );
  plb_ram #(.WIDTH(LQ), .DEPTH(LEVELS)) u_ask_ram (
    .clk(clk), .we(ask_we), .waddr(ask_waddr), .wdata(ask_wdata),
    .raddr(ask_raddr), .rdata(ask_rdata)
  );

  // Saturating add into the addressed level; an empty level reads as zero.
  always_comb begin
    if (cur_r.is_ask) begin
      old_q = na_r[cur_idx] ? ask_rdata : '0;
    end else begin
      old_q = nb_r[cur_idx] ? bid_rdata : '0;
    end
    add_sum = {1'b0, old_q} + (LQ+1)'(cur_r.qty);
    add_q   = add_sum[LQ] ? plb_pkg::LQ_MAX : add_sum[LQ-1:0];
  end

  always_comb begin
    fill_q   = (bid_rdata < ask_rdata) ? bid_rdata : ask_rdata;
    bid_left = bid_rdata - fill_q;
    ask_left = ask_rdata - fill_q;
    ft_sum   = (ft_r >= plb_pkg::FT_MAX || (|fill_q[LQ-1:plb_pkg::FT_W]))
               ? {1'b1, plb_pkg::FT_MAX}
               : {1'b0, ft_r} + {1'b0, fill_q[plb_pkg::FT_W-1:0]};
  end

  assign crossed   = hb && ha && (bb >= ba);
  assign bid_raddr = (st_r == ST_IDLE) ? head_idx : bb;
  assign ask_raddr = (st_r == ST_IDLE) ? head_idx : ba;
  assign bid_we    = (st_r == ST_RD && !cur_r.is_ask) || (st_r == ST_MRD);
  assign ask_we    = (st_r == ST_RD && cur_r.is_ask) || (st_r == ST_MRD);
  assign bid_waddr = (st_r == ST_RD) ? cur_idx : bb;
  assign ask_waddr = (st_r == ST_RD) ? cur_idx : ba;
  assign bid_wdata = (st_r == ST_RD) ? add_q : bid_left;
  assign ask_wdata = (st_r == ST_RD) ? add_q : ask_left;

  assign q_pop    = (st_r == ST_IDLE) && q_valid;
  assign out_load = (st_r == ST_OUT) && (!ov_r || out_chan.ready);

  always_comb begin
    st_nxt   = st_r;
    cur_nxt  = cur_r;
    fc_nxt   = fc_r;
    ft_nxt   = ft_r;
    tt_nxt   = tt_r;
    nb_nxt   = nb_r;
    na_nxt   = na_r;
    ov_nxt   = (ov_r && !out_chan.ready) || out_load;
    o_fc_nxt = o_fc_r;
    o_ft_nxt = o_ft_r;
    o_bb_nxt = o_bb_r;
    o_hb_nxt = o_hb_r;
    o_ba_nxt = o_ba_r;
    o_ha_nxt = o_ha_r;
    o_tt_nxt = o_tt_r;
    o_zr_nxt = o_zr_r;
    case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          cur_nxt = q_item;
          fc_nxt  = '0;
          ft_nxt  = '0;
          st_nxt  = (q_item.kind == plb_pkg::K_ADD) ? ST_RD : ST_S1;
        end
      end
      ST_RD: begin
        if (cur_r.is_ask) begin
          na_nxt[cur_idx] = 1'b1;
        end else begin
          nb_nxt[cur_idx] = 1'b1;
        end
        st_nxt = ST_S1;
      end
      ST_S1: st_nxt = ST_S2;
      ST_S2: st_nxt = ST_CHK;
      ST_CHK: begin
        st_nxt = (cur_r.kind == plb_pkg::K_ADD && crossed) ? ST_MRD : ST_OUT;
      end
      ST_MRD: begin
        nb_nxt[bb] = (bid_left != '0);
        na_nxt[ba] = (ask_left != '0);
        tt_nxt     = tt_r + 1'b1;
        fc_nxt     = (fc_r == plb_pkg::FC_MAX) ? fc_r : fc_r + 1'b1;
        ft_nxt     = ft_sum[plb_pkg::FT_W] ? plb_pkg::FT_MAX : ft_sum[plb_pkg::FT_W-1:0];
        st_nxt     = ST_S1;
      end
      ST_OUT: begin
        if (out_load) begin
          o_fc_nxt = fc_r;
          o_ft_nxt = ft_r;
          o_bb_nxt = plb_pkg::PRICE_W'(bb);
          o_hb_nxt = hb;
          o_ba_nxt = plb_pkg::PRICE_W'(ba);
          o_ha_nxt = ha;
          o_tt_nxt = tt_r;
          o_zr_nxt = (cur_r.kind == plb_pkg::K_ZERO);
          st_nxt   = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      tt_r <= '0;
      nb_r <= '0;
      na_r <= '0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      tt_r <= tt_nxt;
      nb_r <= nb_nxt;
      na_r <= na_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    fc_r   <= fc_nxt;
    ft_r   <= ft_nxt;
    o_fc_r <= o_fc_nxt;
    o_ft_r <= o_ft_nxt;
    o_bb_r <= o_bb_nxt;
    o_hb_r <= o_hb_nxt;
    o_ba_r <= o_ba_nxt;
    o_ha_r <= o_ha_nxt;
    o_tt_r <= o_tt_nxt;
    o_zr_r <= o_zr_nxt;
  end

  assign out_chan.valid          = ov_r;
  assign out_chan.fill_count     = o_fc_r;
  assign out_chan.filled_total   = o_ft_r;
  assign out_chan.best_bid_level = o_bb_r;
  assign out_chan.bid_present    = o_hb_r;
  assign out_chan.best_ask_level = o_ba_r;
  assign out_chan.ask_present    = o_ha_r;
  assign out_chan.trade_total    = o_tt_r;
  assign out_chan.zero_rejected  = o_zr_r;

endmodule
`default_nettype wire

### design/price_level_book_matcher.sv
// Top level of the price-level order book matcher.
// An add with no match passes the states IDLE, RD, S1, S2, CHK and OUT on its way
// to the output register; a zero-quantity or out-of-band request skips RD, and each
// match adds a pass through MRD, S1, S2 and CHK. The back-end sequencer takes a new
// request only in IDLE, so the front queue holds up to two requests meanwhile.
// Reset (rst_n low, synchronous): empties both books via the level-occupied
// bitmaps, clears the trade counter, the queue and the output valid flag.
`default_nettype none
module price_level_book_matcher #(
  parameter int LEVELS = plb_pkg::LEVELS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  plb_in_if.sink    in_chan,
  plb_out_if.source out_chan
);

  // Classified request from the front queue toward the sequencer.
  logic          q_valid;
  plb_pkg::req_t q_item;
  logic          q_pop;

  // Front: take a request whenever the queue has room, tag it as add,
  // zero-quantity reject or out-of-band, and hold it until the back is free.
  plb_front #(.LEVELS(LEVELS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  // Back: for an add, add into the level and loop match/search while the book is
  // crossed; then drop the result into the output register.
  plb_back #(.LEVELS(LEVELS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item),
    .q_pop(q_pop), .out_chan(out_chan)
  );

  // A rejected request never trades.
  a_reject_no_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.zero_rejected |->
      out_chan.fill_count == '0 && out_chan.filled_total == '0)
    else $error("rejected request reports fills");

  // After matching the book is never left crossed.
  a_not_crossed: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.bid_present && out_chan.ask_present |->
      out_chan.best_bid_level < out_chan.best_ask_level)
    else $error("book left crossed");

  // Fill count is zero exactly when the filled quantity is zero: every match moves a nonzero quantity.
  a_fill_qty: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.fill_count == '0) == (out_chan.filled_total == '0))
    else $error("fill count and filled quantity disagree");

endmodule
`default_nettype wire
